@@ rtl/core/hffa_pkg.sv @@
// ----------------------------------------------------------------------------
// hffa_pkg: shared definitions for the hemicube form factor accumulator
// Sizes, request and result layouts, operation and status codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hffa_pkg;

  localparam int MAX_HALF_RES = 64;
  localparam int MAX_PATCHES  = 4096;
  localparam int TABLE_DEPTH  = MAX_HALF_RES * MAX_HALF_RES;

  localparam int ROW_W    = 7;
  localparam int HR_W     = 7;
  localparam int SR_W     = 7;
  localparam int RL_W     = 8;
  localparam int ID_W     = 24;
  localparam int FIDX_W   = 12;
  localparam int FVAL_W   = 32;
  localparam int ACC_W    = 40;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam int PATCH_AW = $clog2(MAX_PATCHES);
  localparam int TABLE_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int Q_W      = (MAX_HALF_RES > 1) ? $clog2(MAX_HALF_RES) : 1;
  localparam int STEP_W   = $clog2(ROW_W);

  localparam logic [ID_W-1:0] BACKGROUND_ID = {ID_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_RES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SKIP  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [ID_W-1:0]   patch_id;
    logic [FIDX_W-1:0] factor_index;
    logic [FVAL_W-1:0] factor_value;
  } request_t;

  typedef struct packed {
    logic [ACC_W-1:0] form_factor;
    status_t          status;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic    capture;
    logic    mod_start;
    logic    mod_step;
    logic    addr_calc;
    logic    mem_read;
    logic    table_write;
    logic    acc_clear;
    logic    acc_update;
    logic    clear_step;
    logic    finish;
    logic    ff_sel;
    status_t code;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  op;
    logic skip;
    logic range;
    logic sat;
    logic mod_last;
    logic clear_last;
  } stat_t;

endpackage

@@ rtl/core/hffa_datapath.sv @@
// ----------------------------------------------------------------------------
// hffa_datapath: registers, remainder unit, address multiply and memories
// Holds the configuration, the captured request, the delta factor table,
// the accumulator store and the result register.
// ----------------------------------------------------------------------------
module hffa_datapath import hffa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  request_t             request,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 done,
  output result_t              result
);

  logic [HR_W-1:0]     half_res;
  logic [SR_W-1:0]     start_row;
  logic [RL_W-1:0]     row_limit;
  request_t            req;
  logic [HR_W-1:0]     h;
  logic [PATCH_AW-1:0] pid;

  logic [STEP_W-1:0]   step;
  logic [HR_W-1:0]     rrem;
  logic [HR_W-1:0]     crem;
  logic [HR_W-1:0]     rrem_next;
  logic [HR_W-1:0]     crem_next;
  logic [HR_W:0]       rtry;
  logic [HR_W:0]       ctry;

  logic [Q_W-1:0]      qrow;
  logic [Q_W-1:0]      qcol;
  logic [Q_W+HR_W-1:0] addr_full;
  logic [TABLE_AW-1:0] tbl_addr;

  logic [FVAL_W-1:0]   tbl_mem [TABLE_DEPTH];
  logic [ACC_W-1:0]    acc_mem [MAX_PATCHES];
  logic [FVAL_W-1:0]   tbl_rdata;
  logic [ACC_W-1:0]    acc_rdata;
  logic [ACC_W:0]      sum;
  logic [ACC_W-1:0]    acc_new;
  logic [PATCH_AW-1:0] clr_cnt;

  logic                wr_en;
  logic [PATCH_AW-1:0] wr_addr;
  logic [ACC_W-1:0]    wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_res  <= HR_W'(64);
      start_row <= '0;
      row_limit <= RL_W'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_RES:  half_res  <= cfg_data[HR_W-1:0];
        CFG_START_ROW: start_row <= cfg_data[SR_W-1:0];
        CFG_ROW_LIMIT: row_limit <= cfg_data[RL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
  end

  assign h   = (int'(half_res) > MAX_HALF_RES) ? HR_W'(MAX_HALF_RES) : half_res;
  assign pid = req.patch_id[PATCH_AW-1:0];

  // Request checks on the captured request, plus the remainder, saturation
  // and clearing pass status.
  always_comb begin
    stat.op    = req.op;
    stat.skip  = (req.patch_id == BACKGROUND_ID) || (h == '0) ||
                 (req.row < start_row) ||
                 ({1'b0, req.row} >= row_limit) ||
                 ({1'b0, req.col} >= {h, 1'b0});
    if (req.op == OP_LOAD) begin
      stat.range = {1'b0, req.factor_index} >= (FIDX_W+1)'(TABLE_DEPTH);
    end else begin
      stat.range = {1'b0, req.patch_id} >= (ID_W+1)'(MAX_PATCHES);
    end
    stat.mod_last   = (step == '0);
    stat.sat        = sum[ACC_W];
    stat.clear_last = (clr_cnt == PATCH_AW'(MAX_PATCHES - 1));
  end

  // Restoring remainder of row and column by h, one bit per cycle.
  assign rtry = {rrem, req.row[step]};
  assign ctry = {crem, req.col[step]};
  assign rrem_next = (rtry >= {1'b0, h}) ? HR_W'(rtry - {1'b0, h}) : rtry[HR_W-1:0];
  assign crem_next = (ctry >= {1'b0, h}) ? HR_W'(ctry - {1'b0, h}) : ctry[HR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      step <= STEP_W'(ROW_W - 1);
      rrem <= '0;
      crem <= '0;
    end else if (cmd.mod_step) begin
      step <= step - STEP_W'(1);
      rrem <= rrem_next;
      crem <= crem_next;
    end
  end

  // Mirror into the quadrant and form the table address.
  assign qrow = (req.row < h) ? Q_W'(req.row) : Q_W'(h - HR_W'(1) - rrem);
  assign qcol = (req.col < h) ? Q_W'(req.col) : Q_W'(h - HR_W'(1) - crem);
  assign addr_full = qrow * h + (Q_W+HR_W)'(qcol);

  always_ff @(posedge clk) begin
    if (cmd.addr_calc) begin
      tbl_addr <= addr_full[TABLE_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.table_write) begin
      tbl_mem[req.factor_index[TABLE_AW-1:0]] <= req.factor_value;
    end
    if (cmd.mem_read) begin
      tbl_rdata <= tbl_mem[tbl_addr];
    end
  end

  // Saturating accumulate.
  assign sum      = {1'b0, acc_rdata} + (ACC_W+1)'(tbl_rdata);
  assign acc_new  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + PATCH_AW'(1);
    end
  end

  always_comb begin
    wr_en   = cmd.clear_step || cmd.acc_clear || cmd.acc_update;
    wr_addr = cmd.clear_step ? clr_cnt : pid;
    wr_data = cmd.acc_update ? acc_new : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_read) begin
      acc_rdata <= acc_mem[pid];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.form_factor <= cmd.ff_sel ? acc_rdata : '0;
      result.status      <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

@@ rtl/core/hffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// hffa_ctrl: sequencing state machine
// Runs the accumulator clearing pass after reset, then steps each request
// through decode, remainder, address, fetch and update as its op needs.
// ----------------------------------------------------------------------------
module hffa_ctrl import hffa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_ADDR   = 7'b0010000,
    S_FETCH  = 7'b0100000,
    S_UPDATE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_DONE;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.capture = start;
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_LOAD: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
            if (stat.range) begin
              cmd.code = ST_RANGE;
            end else begin
              cmd.table_write = 1'b1;
            end
          end
          OP_PIXEL: begin
            if (stat.skip) begin
              cmd.finish = 1'b1;
              cmd.code   = ST_SKIP;
              state_next = S_IDLE;
            end else if (stat.range) begin
              cmd.finish = 1'b1;
              cmd.code   = ST_RANGE;
              state_next = S_IDLE;
            end else begin
              cmd.mod_start = 1'b1;
              state_next    = S_MOD;
            end
          end
          OP_READ: begin
            if (stat.range) begin
              cmd.finish = 1'b1;
              cmd.code   = ST_RANGE;
              state_next = S_IDLE;
            end else begin
              cmd.mem_read = 1'b1;
              state_next   = S_UPDATE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
            if (stat.range) begin
              cmd.code = ST_RANGE;
            end else begin
              cmd.acc_clear = 1'b1;
            end
          end
        endcase
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr_calc = 1'b1;
        state_next    = S_FETCH;
      end
      S_FETCH: begin
        cmd.mem_read = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
        if (stat.op == OP_READ) begin
          cmd.ff_sel = 1'b1;
        end else begin
          cmd.acc_update = 1'b1;
          cmd.code       = stat.sat ? ST_SAT : ST_DONE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE))
    else $error("controller did not return to idle after a result");

  a_one_acc_write: assert property (@(posedge clk) disable iff (rst)
    !((cmd.clear_step && (cmd.acc_clear || cmd.acc_update)) ||
      (cmd.acc_clear && cmd.acc_update)))
    else $error("two accumulator writes requested in one cycle");

  a_addr_after_mod: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> ($past(state) == S_MOD))
    else $error("address step entered without the remainder steps");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !busy)
    else $error("request captured while busy");

endmodule

@@ rtl/core/hemicube_form_factor_accumulate.sv @@
// ----------------------------------------------------------------------------
// hemicube_form_factor_accumulate: hemicube form factor summation
// Sums delta form factors from an item-buffer pixel stream into per-patch
// saturating Q8.32 accumulators; also loads the factor table, reads and
// clears accumulators.
// ----------------------------------------------------------------------------
// Sequence: a load, a clear, a skipped pixel or a rejected id finishes in
// the decode state; a read adds the update state; an accumulate adds the
// 7-step remainder unit, the address step and the registered table and
// accumulator reads. A new request is taken only once busy is low again.
// Reset: synchronous; busy stays high while the clearing pass zeroes
// every accumulator. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module hemicube_form_factor_accumulate import hffa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  request_t             request,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // The controller issues one command bundle per cycle; the datapath
  // reports request checks, remainder progress, saturation and the
  // clearing pass position back.
  cmd_t  cmd;
  stat_t stat;

  // Controller: accepts a request when start is high and busy is low,
  // and walks it through the steps its op needs.
  hffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: configuration registers, the mirror remainder unit, the
  // table address multiply, both memories and the result register.
  hffa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule
